@@ rtl/ebalu_pkg.sv @@
// Package: operation codes, payload structs and flag type for the 8-bit ALU.
`timescale 1ns / 1ps
package ebalu_pkg;

    // Operation codes
    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_ADC   = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_SBC   = 5'd3;
    localparam logic [4:0] OP_CP    = 5'd4;
    localparam logic [4:0] OP_INC   = 5'd5;
    localparam logic [4:0] OP_DEC   = 5'd6;
    localparam logic [4:0] OP_RLC   = 5'd7;
    localparam logic [4:0] OP_RRC   = 5'd8;
    localparam logic [4:0] OP_RL    = 5'd9;
    localparam logic [4:0] OP_RR    = 5'd10;
    localparam logic [4:0] OP_SLA   = 5'd11;
    localparam logic [4:0] OP_SRA   = 5'd12;
    localparam logic [4:0] OP_SRL   = 5'd13;
    localparam logic [4:0] OP_SWAP  = 5'd14;
    localparam logic [4:0] OP_BIT   = 5'd15;
    localparam logic [4:0] OP_SET   = 5'd16;
    localparam logic [4:0] OP_RES   = 5'd17;
    localparam logic [4:0] OP_ADD16 = 5'd18;
    localparam logic [4:0] OP_LOAD  = 5'd19;

    // Flag register, bit 3 down to bit 0
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    // Input item
    typedef struct packed {
        logic [4:0]  req_type;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } t_alu_req;

    // Result item
    typedef struct packed {
        logic [15:0] result_value;
        logic [7:0]  acc_value;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_flag;
        logic        carry_flag;
    } t_alu_rsp;

endpackage

@@ rtl/ebalu_exec.sv @@
// Combinational execute unit: one operation against the current accumulator and flags.
`timescale 1ns / 1ps
module ebalu_exec
    import ebalu_pkg::*;
(
    input  t_alu_req    i_req,
    input  logic [7:0]  i_acc,
    input  t_flags      i_flags,
    output logic [15:0] o_result,
    output logic [7:0]  o_acc,
    output t_flags      o_flags
);

    logic [7:0]  w_v;
    logic        w_cin;
    logic        w_t;
    logic [8:0]  w_sum;
    logic [4:0]  w_hsum;
    logic [8:0]  w_diff;
    logic [4:0]  w_hdiff;
    logic [16:0] w_sum16;
    logic [12:0] w_hsum16;
    logic [7:0]  w_mask;
    logic [7:0]  w_byte;

    assign w_v   = i_req.operand_a[7:0];
    assign w_cin = i_flags.c;

    // carry-in only for adc / sbc
    assign w_t = ((i_req.req_type == OP_ADC) || (i_req.req_type == OP_SBC)) ? w_cin : 1'b0;

    // shared adders / subtractors
    assign w_sum    = {1'b0, i_acc} + {1'b0, w_v} + {8'd0, w_t};
    assign w_hsum   = {1'b0, i_acc[3:0]} + {1'b0, w_v[3:0]} + {4'd0, w_t};
    assign w_diff   = {1'b0, i_acc} - {1'b0, w_v} - {8'd0, w_t};
    assign w_hdiff  = {1'b0, i_acc[3:0]} - {1'b0, w_v[3:0]} - {4'd0, w_t};
    assign w_sum16  = {1'b0, i_req.operand_a} + {1'b0, i_req.operand_b};
    assign w_hsum16 = {1'b0, i_req.operand_a[11:0]} + {1'b0, i_req.operand_b[11:0]};
    assign w_mask   = 8'd1 << i_req.bit_index;

    // operation decode
    always_comb begin
        o_result = 16'd0;
        o_acc    = i_acc;
        o_flags  = i_flags;
        w_byte   = 8'd0;
        unique case (i_req.req_type) inside
            OP_ADD, OP_ADC: begin
                o_result = {8'd0, w_sum[7:0]};
                o_acc    = w_sum[7:0];
                o_flags  = '{z: (w_sum[7:0] == 8'd0), n: 1'b0, h: w_hsum[4], c: w_sum[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                o_result = {8'd0, w_diff[7:0]};
                if (i_req.req_type != OP_CP) begin
                    o_acc = w_diff[7:0];
                end
                o_flags = '{z: (w_diff[7:0] == 8'd0), n: 1'b1, h: w_hdiff[4], c: w_diff[8]};
            end
            OP_INC: begin
                w_byte   = w_v + 8'd1;
                o_result = {8'd0, w_byte};
                o_flags  = '{z: (w_byte == 8'd0), n: 1'b0, h: (w_v[3:0] == 4'hf), c: w_cin};
            end
            OP_DEC: begin
                w_byte   = w_v - 8'd1;
                o_result = {8'd0, w_byte};
                o_flags  = '{z: (w_byte == 8'd0), n: 1'b1, h: (w_v[3:0] == 4'h0), c: w_cin};
            end
            OP_RLC, OP_RL, OP_SLA: begin
                // left shifts: bit 7 goes to carry
                case (i_req.req_type)
                    OP_RLC:  w_byte = {w_v[6:0], w_v[7]};
                    OP_RL:   w_byte = {w_v[6:0], w_cin};
                    default: w_byte = {w_v[6:0], 1'b0};
                endcase
                o_result = {8'd0, w_byte};
                o_flags  = '{z: (w_byte == 8'd0), n: 1'b0, h: 1'b0, c: w_v[7]};
            end
            OP_RRC, OP_RR, OP_SRA, OP_SRL: begin
                // right shifts: bit 0 goes to carry
                case (i_req.req_type)
                    OP_RRC:  w_byte = {w_v[0], w_v[7:1]};
                    OP_RR:   w_byte = {w_cin, w_v[7:1]};
                    OP_SRA:  w_byte = {w_v[7], w_v[7:1]};
                    default: w_byte = {1'b0, w_v[7:1]};
                endcase
                o_result = {8'd0, w_byte};
                o_flags  = '{z: (w_byte == 8'd0), n: 1'b0, h: 1'b0, c: w_v[0]};
            end
            OP_SWAP: begin
                w_byte   = {w_v[3:0], w_v[7:4]};
                o_result = {8'd0, w_byte};
                o_flags  = '{z: (w_byte == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_BIT: begin
                o_result = {8'd0, w_v};
                o_flags  = '{z: ((w_v & w_mask) == 8'd0), n: 1'b0, h: 1'b1, c: w_cin};
            end
            OP_SET: begin
                o_result = {8'd0, w_v | w_mask};
            end
            OP_RES: begin
                o_result = {8'd0, w_v & ~w_mask};
            end
            OP_ADD16: begin
                o_result = w_sum16[15:0];
                o_flags  = '{z: i_flags.z, n: 1'b0, h: w_hsum16[12], c: w_sum16[16]};
            end
            OP_LOAD: begin
                o_result = {8'd0, w_v};
                o_acc    = w_v;
                o_flags  = t_flags'(i_req.flags_in);
            end
            default: begin
                // unused codes: no state change, zero result
                o_result = 16'd0;
            end
        endcase
    end

endmodule

@@ rtl/eight_bit_alu_with_flags_core.sv @@
// Top level: 8-bit ALU with accumulator and Z/N/H/C flags, input and result registers.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  request | in        | i_in_valid / o_in_ready    | i_in_data  (t_alu_req)
//  result  | out       | o_out_valid / i_out_ready  | o_out_data (t_alu_rsp)
//
// Request register feeds result register; one item per cycle unless output stalls.
// The execute unit sits between the request register and the result register, and the
// accumulator and flags update in the same cycle the result register loads.
// Reset clears the valid bits, the accumulator and the flags.
// A stalled result holds; the request register still takes one more item behind it.
`timescale 1ns / 1ps
module eight_bit_alu_with_flags_core
    import ebalu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_alu_req i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_alu_rsp o_out_data
);

    logic        r_in_vld;
    t_alu_req    r_in;
    logic        r_out_vld;
    t_alu_rsp    r_out;
    logic [7:0]  r_acc;
    t_flags      r_flags;

    logic        w_adv;
    logic [15:0] w_result;
    logic [7:0]  n_acc;
    t_flags      n_flags;

    // stage advance: request held and result slot free or draining
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    ebalu_exec u_exec (
        .i_req    (r_in),
        .i_acc    (r_acc),
        .i_flags  (r_flags),
        .o_result (w_result),
        .o_acc    (n_acc),
        .o_flags  (n_flags)
    );

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 8'd0;
            r_flags <= '0;
        end else if (w_adv) begin
            r_acc   <= n_acc;
            r_flags <= n_flags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv) begin
            r_out.result_value  <= w_result;
            r_out.acc_value     <= n_acc;
            r_out.zero_flag     <= n_flags.z;
            r_out.subtract_flag <= n_flags.n;
            r_out.half_flag     <= n_flags.h;
            r_out.carry_flag    <= n_flags.c;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // state only moves when an item executes
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_acc) && $stable(r_flags)))
        else $error("accumulator or flags changed without an executing item");

    // a fresh result always reports the state it left behind
    a_rsp_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out.acc_value == r_acc && r_out.zero_flag == r_flags.z
                   && r_out.carry_flag == r_flags.c))
        else $error("result fields disagree with accumulator or flags");

    // a held request is never overwritten
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_in)))
        else $error("pending request lost or overwritten");

    // set and res leave the flags alone
    a_bitop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in.req_type == OP_SET || r_in.req_type == OP_RES))
        |=> (r_flags == $past(r_flags)))
        else $error("set/res modified flags");

endmodule
